>>> src/twd_pkg.sv
// twd_pkg: types, codes and sizes shared by the task liveness watchdog
// used by twd_entry_ram and task_liveness_watchdog; depends on nothing
`default_nettype none

package twd_pkg;

    // number of monitored tasks and derived index width
    localparam int TASKS = 8;
    localparam int IDX_W = (TASKS > 1) ? $clog2(TASKS) : 1;

    // event modes
    localparam logic [2:0] MODE_CONFIG = 3'd0;
    localparam logic [2:0] MODE_START  = 3'd1;
    localparam logic [2:0] MODE_END    = 3'd2;
    localparam logic [2:0] MODE_HELLO  = 3'd3;
    localparam logic [2:0] MODE_SETACT = 3'd4;
    localparam logic [2:0] MODE_TICK   = 3'd5;

    // usage error codes
    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_START  = 2'd1;
    localparam logic [1:0] ERR_END    = 2'd2;
    localparam logic [1:0] ERR_CFG_ID = 2'd3;

    // fatal causes
    localparam logic [1:0] CAUSE_NONE    = 2'd0;
    localparam logic [1:0] CAUSE_ERROR   = 2'd1;
    localparam logic [1:0] CAUSE_TIMEOUT = 2'd2;

    // input event payload
    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] task_id;
        logic [7:0] timeout;
        logic       active;
    } twd_event_t;

    // result payload
    typedef struct packed {
        logic       fatal;
        logic [1:0] fatal_cause;
        logic [1:0] error_code;
        logic [5:0] failed_task;
    } twd_status_t;

    // one task entry as held in the entry memory
    typedef struct packed {
        logic [7:0] limit;
        logic [7:0] count;
        logic       configured;
        logic       active;
        logic       entered;
    } twd_entry_t;

    // memory access request from the sequencer
    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        twd_entry_t       wr_data;
    } twd_ram_req_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVENT,
        ST_WALK,
        ST_FINISH
    } twd_state_t;

endpackage

`default_nettype wire

>>> src/twd_entry_ram.sv
// twd_entry_ram: task entry memory, one write and one registered read per cycle
// entries never written read as zero through per-entry valid bits; uses twd_pkg
`default_nettype none

module twd_entry_ram (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire twd_pkg::twd_ram_req_t req,
    output      twd_pkg::twd_entry_t   rd_data
);

    twd_pkg::twd_entry_t mem [twd_pkg::TASKS];
    twd_pkg::twd_entry_t data_reg;
    logic [twd_pkg::TASKS-1:0] valid_reg;
    logic rd_valid_reg;

    // storage write and registered read
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            data_reg <= mem[req.rd_addr];
        end
    end

    // valid bits give the zero reset value of every entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_valid_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? data_reg : '0;

endmodule

`default_nettype wire

>>> src/task_liveness_watchdog.sv
// task_liveness_watchdog: top level, event sequencer and status registers
// depends on twd_pkg and twd_entry_ram
`default_nettype none

// Per-task liveness watchdog.
// Events come in on evt (valid/ready); one status transfer goes out on stat
// (valid/ready) for every event, showing the state after that event.
// Task entries live in a synchronous memory whose read data arrives in the cycle
// after the address is issued; configure, start, end, hello and set active with an
// in-range task each do one read-modify-write of their entry. These events, unused
// modes and a tick with a stored error pass through ST_EVENT, then ST_FINISH.
// A tick walk (ST_WALK) runs to the end or stops on a timed-out task: the walk
// reads entry i+1 while it writes back entry i, one entry per cycle through the
// single memory port pair.
// Events are taken one at a time: evt_ready is high only while idle.
// The status output is registered; the next event is accepted while a status
// waits, and its own status is held back until the waiting one is taken.
// Reset clears all entries (via valid bits), the usage error, the fatal latch
// and its cause and task; no clearing pass is needed, evt_ready rises at once.
module task_liveness_watchdog (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                evt_valid,
    output      logic                evt_ready,
    input  wire twd_pkg::twd_event_t  evt,
    output      logic                stat_valid,
    input  wire logic                stat_ready,
    output      twd_pkg::twd_status_t stat
);

    twd_pkg::twd_state_t state_reg, state_next;
    twd_pkg::twd_event_t evt_reg, evt_next;
    logic [twd_pkg::IDX_W-1:0] walk_idx_reg, walk_idx_next;
    logic [1:0] usage_error_reg, usage_error_next;
    logic       fatal_reg, fatal_next;
    logic [1:0] reason_reg, reason_next;
    logic [5:0] failed_reg, failed_next;
    logic       stat_valid_reg, stat_valid_next;
    twd_pkg::twd_status_t stat_reg, stat_next;

    twd_pkg::twd_ram_req_t ram_req;
    twd_pkg::twd_entry_t   rd_data;

    logic evt_xfer;
    logic in_range;

    twd_entry_ram u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (ram_req),
        .rd_data (rd_data)
    );

    assign evt_xfer  = evt_valid && evt_ready;
    assign evt_ready = (state_reg == twd_pkg::ST_IDLE);
    assign in_range  = (evt_reg.task_id < 8'(twd_pkg::TASKS));
    assign stat_valid = stat_valid_reg;
    assign stat       = stat_reg;

    // state and payload registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= twd_pkg::ST_IDLE;
            usage_error_reg <= twd_pkg::ERR_NONE;
            fatal_reg       <= 1'b0;
            reason_reg      <= twd_pkg::CAUSE_NONE;
            failed_reg      <= '0;
            stat_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            usage_error_reg <= usage_error_next;
            fatal_reg       <= fatal_next;
            reason_reg      <= reason_next;
            failed_reg      <= failed_next;
            stat_valid_reg  <= stat_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        evt_reg      <= evt_next;
        walk_idx_reg <= walk_idx_next;
        stat_reg     <= stat_next;
    end

    // sequencer: next state, entry update and status update
    always_comb
    begin
        twd_pkg::twd_entry_t e1;
        twd_pkg::twd_entry_t e2;
        logic do_start;
        logic do_end;

        state_next       = state_reg;
        evt_next         = evt_reg;
        walk_idx_next    = walk_idx_reg;
        usage_error_next = usage_error_reg;
        fatal_next       = fatal_reg;
        reason_next      = reason_reg;
        failed_next      = failed_reg;
        stat_next        = stat_reg;
        stat_valid_next  = stat_valid_reg;
        ram_req          = '0;
        e1               = rd_data;
        e2               = rd_data;
        do_start         = 1'b0;
        do_end           = 1'b0;

        // output slot drains on a stat transfer
        if (stat_valid_reg && stat_ready)
        begin
            stat_valid_next = 1'b0;
        end

        unique case (state_reg)
            twd_pkg::ST_IDLE:
            begin
                if (evt_xfer)
                begin
                    evt_next      = evt;
                    walk_idx_next = '0;
                    ram_req.rd_en = 1'b1;
                    if (evt.mode == twd_pkg::MODE_TICK)
                    begin
                        ram_req.rd_addr = '0;
                    end
                    else
                    begin
                        ram_req.rd_addr = evt.task_id[twd_pkg::IDX_W-1:0];
                    end
                    if (evt.mode == twd_pkg::MODE_TICK && usage_error_reg == twd_pkg::ERR_NONE)
                    begin
                        state_next = twd_pkg::ST_WALK;
                    end
                    else
                    begin
                        state_next = twd_pkg::ST_EVENT;
                    end
                end
            end

            twd_pkg::ST_EVENT:
            begin
                state_next = twd_pkg::ST_FINISH;
                do_start = (evt_reg.mode == twd_pkg::MODE_START)
                        || (evt_reg.mode == twd_pkg::MODE_HELLO);
                do_end   = (evt_reg.mode == twd_pkg::MODE_END)
                        || (evt_reg.mode == twd_pkg::MODE_HELLO);

                // configure and set active
                if (evt_reg.mode == twd_pkg::MODE_CONFIG)
                begin
                    if (in_range)
                    begin
                        e1.limit      = evt_reg.timeout;
                        e1.count      = '0;
                        e1.configured = 1'b1;
                        e1.active     = evt_reg.active;
                    end
                    else
                    begin
                        usage_error_next = twd_pkg::ERR_CFG_ID;
                    end
                end
                if (evt_reg.mode == twd_pkg::MODE_SETACT && in_range && rd_data.configured)
                begin
                    e1.active = evt_reg.active;
                end

                // start bracket
                if (do_start)
                begin
                    if (in_range && rd_data.configured && rd_data.active && !rd_data.entered)
                    begin
                        e1.entered = 1'b1;
                    end
                    else
                    begin
                        usage_error_next = twd_pkg::ERR_START;
                    end
                end

                // end bracket, seen after start for hello
                e2 = e1;
                if (do_end)
                begin
                    if (in_range && e1.configured && e1.entered)
                    begin
                        e2.entered = 1'b0;
                        e2.count   = '0;
                    end
                    else
                    begin
                        usage_error_next = twd_pkg::ERR_END;
                    end
                end

                // tick with a stored error skips the walk
                if (evt_reg.mode == twd_pkg::MODE_TICK)
                begin
                    fatal_next  = 1'b1;
                    reason_next = twd_pkg::CAUSE_ERROR;
                end

                ram_req.wr_en   = in_range && (evt_reg.mode <= twd_pkg::MODE_SETACT);
                ram_req.wr_addr = evt_reg.task_id[twd_pkg::IDX_W-1:0];
                ram_req.wr_data = e2;
            end

            twd_pkg::ST_WALK:
            begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = walk_idx_reg;
                if (rd_data.configured && rd_data.active)
                begin
                    if (rd_data.count < rd_data.limit)
                    begin
                        e1.count = rd_data.count + 8'd1;
                    end
                    else
                    begin
                        e1.entered  = 1'b0;
                        fatal_next  = 1'b1;
                        reason_next = twd_pkg::CAUSE_TIMEOUT;
                        failed_next = 6'(walk_idx_reg);
                    end
                end
                else
                begin
                    e1.entered = 1'b0;
                end
                ram_req.wr_data = e1;

                // stop on a timeout or after the last entry, else read ahead
                if ((rd_data.configured && rd_data.active && !(rd_data.count < rd_data.limit))
                    || walk_idx_reg == twd_pkg::IDX_W'(twd_pkg::TASKS - 1))
                begin
                    state_next = twd_pkg::ST_FINISH;
                end
                else
                begin
                    walk_idx_next   = walk_idx_reg + 1'b1;
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = walk_idx_reg + 1'b1;
                end
            end

            twd_pkg::ST_FINISH:
            begin
                if (!stat_valid_reg || stat_ready)
                begin
                    stat_next.fatal       = fatal_reg;
                    stat_next.fatal_cause = reason_reg;
                    stat_next.error_code  = usage_error_reg;
                    stat_next.failed_task = failed_reg;
                    stat_valid_next       = 1'b1;
                    state_next            = twd_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = twd_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    // the walk never reads the entry it is writing back
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_req.rd_en && ram_req.wr_en) |-> (ram_req.rd_addr != ram_req.wr_addr))
        else $error("entry memory read and write hit the same entry");

    // the fatal latch never clears
    a_fatal_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        fatal_reg |=> fatal_reg)
        else $error("fatal latch cleared");

    // walk index stays within the task table
    a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == twd_pkg::ST_WALK) |-> (walk_idx_reg <= twd_pkg::IDX_W'(twd_pkg::TASKS - 1)))
        else $error("walk index beyond last task");

    // an accepted event always starts its memory access
    a_evt_starts: assert property (@(posedge clk) disable iff (!rst_n)
        evt_xfer |=> (state_reg == twd_pkg::ST_EVENT || state_reg == twd_pkg::ST_WALK))
        else $error("accepted event did not start processing");

    // a recorded fatal cause always comes with the fatal latch set
    a_cause_fatal: assert property (@(posedge clk) disable iff (!rst_n)
        (reason_reg != twd_pkg::CAUSE_NONE) |-> fatal_reg)
        else $error("fatal cause recorded without fatal latch");
`endif

endmodule

`default_nettype wire

>>> test/twd_status_checker.sv
// twd_status_checker: predicts the status of every event transfer and compares it
// with the status transfers of the task liveness watchdog
// depends on twd_pkg
`default_nettype none

module twd_status_checker
    import twd_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         evt_valid,
    input  wire logic         evt_ready,
    input  wire twd_event_t   evt,
    input  wire logic         stat_valid,
    input  wire logic         stat_ready,
    input  wire twd_status_t  stat,
    output int                fault_count,
    output int                backlog,
    output logic [TASKS-1:0]  configured_mask,
    output logic [TASKS-1:0]  active_mask,
    output logic [TASKS-1:0]  entered_mask
);
    timeunit 1ns;
    timeprecision 1ps;

    // predicted task table and status registers
    logic [7:0]       limit_mem [TASKS];
    logic [7:0]       count_mem [TASKS];
    logic [TASKS-1:0] cfg_bits;
    logic [TASKS-1:0] act_bits;
    logic [TASKS-1:0] ent_bits;
    logic [1:0]       usage_err;
    logic             fatal_flag;
    logic [1:0]       fatal_why;
    logic [5:0]       culprit;

    // statuses predicted but not yet seen, oldest first
    twd_status_t      pending_status [$];

    assign configured_mask = cfg_bits;
    assign active_mask     = act_bits;
    assign entered_mask    = ent_bits;

    // start of an activity: needs a configured, active, not yet entered task
    function automatic void open_activity(input logic [7:0] id);
        if (id < TASKS && cfg_bits[id] && act_bits[id] && !ent_bits[id])
            ent_bits[id] = 1'b1;
        else
            usage_err = ERR_START;
    endfunction

    // end of an activity: needs a configured, entered task; restarts its count
    function automatic void close_activity(input logic [7:0] id);
        if (id < TASKS && cfg_bits[id] && ent_bits[id])
        begin
            ent_bits[id]  = 1'b0;
            count_mem[id] = '0;
        end
        else
            usage_err = ERR_END;
    endfunction

    // apply one event to the predicted state and return the status after it
    function automatic twd_status_t apply_event(input twd_event_t ev);
        twd_status_t s;
        case (ev.mode)
            MODE_CONFIG:
                if (ev.task_id < TASKS)
                begin
                    limit_mem[ev.task_id] = ev.timeout;
                    count_mem[ev.task_id] = '0;
                    cfg_bits[ev.task_id]  = 1'b1;
                    act_bits[ev.task_id]  = ev.active;
                end
                else
                    usage_err = ERR_CFG_ID;
            MODE_START:
                open_activity(ev.task_id);
            MODE_END:
                close_activity(ev.task_id);
            MODE_HELLO:
            begin
                open_activity(ev.task_id);
                close_activity(ev.task_id);
            end
            MODE_SETACT:
                if (ev.task_id < TASKS && cfg_bits[ev.task_id])
                    act_bits[ev.task_id] = ev.active;
            MODE_TICK:
                // a stored usage error skips the walk entirely
                if (usage_err != ERR_NONE)
                begin
                    fatal_flag = 1'b1;
                    fatal_why  = CAUSE_ERROR;
                end
                else
                begin
                    for (int i = 0; i < TASKS; i++)
                    begin
                        if (cfg_bits[i] && act_bits[i])
                        begin
                            if (count_mem[i] < limit_mem[i])
                                count_mem[i] = count_mem[i] + 8'd1;
                            else
                            begin
                                // first timed-out task ends the walk
                                ent_bits[i] = 1'b0;
                                fatal_flag  = 1'b1;
                                fatal_why   = CAUSE_TIMEOUT;
                                culprit     = 6'(i);
                                break;
                            end
                        end
                        else
                            ent_bits[i] = 1'b0;
                    end
                end
            default:
                ;
        endcase
        s.fatal       = fatal_flag;
        s.fatal_cause = fatal_why;
        s.error_code  = usage_err;
        s.failed_task = culprit;
        return s;
    endfunction

    task automatic check_field(input string label, input logic [5:0] want_v,
                               input logic [5:0] got_v);
        if (got_v !== want_v)
        begin
            fault_count++;
            $display("%0t ns: %s expected %0d, got %0d", $time, label, want_v, got_v);
        end
    endtask

    // watch both channels at the rising edge
    always @(posedge clk)
    begin
        twd_status_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < TASKS; i++)
            begin
                limit_mem[i] = '0;
                count_mem[i] = '0;
            end
            cfg_bits    = '0;
            act_bits    = '0;
            ent_bits    = '0;
            usage_err   = ERR_NONE;
            fatal_flag  = 1'b0;
            fatal_why   = CAUSE_NONE;
            culprit     = '0;
            fault_count = 0;
            pending_status.delete();
        end
        else
        begin
            // status transfer: compare with the oldest prediction
            if (stat_valid && stat_ready)
            begin
                if (pending_status.size() == 0)
                begin
                    fault_count++;
                    $display("%0t ns: status transfer %h with none predicted, got %h",
                             $time, twd_status_t'(0), stat);
                end
                else
                begin
                    want = pending_status.pop_front();
                    check_field("fatal", 6'(want.fatal), 6'(stat.fatal));
                    check_field("fatal_cause", 6'(want.fatal_cause), 6'(stat.fatal_cause));
                    check_field("error_code", 6'(want.error_code), 6'(stat.error_code));
                    check_field("failed_task", want.failed_task, stat.failed_task);
                end
            end
            // event transfer: predict its status
            if (evt_valid && evt_ready)
                pending_status.push_back(apply_event(evt));
        end
        backlog = pending_status.size();
    end

endmodule

`default_nettype wire

>>> test/task_liveness_watchdog_test.sv
// task_liveness_watchdog_test: clock, reset, event and status stimulus, verdict
// depends on twd_pkg, task_liveness_watchdog and twd_status_checker
`default_nettype none

module task_liveness_watchdog_test;
    timeunit 1ns;
    timeprecision 1ps;
    import twd_pkg::*;

    localparam int CLK_PERIOD  = 8;
    localparam int STALL_LIMIT = 1000;
    localparam int HOLD_CYCLES = 200;
    localparam int SETTLE      = 16;
    localparam int PHASE_ITEMS = 300;
    localparam int NOISE_ITEMS = 100;

    // modes the block ignores
    localparam logic [2:0] MODE_SPARE_LO = 3'd6;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;

    logic             clk;
    logic             rst_n;
    logic             evt_valid;
    logic             evt_ready;
    twd_event_t       evt;
    logic             stat_valid;
    logic             stat_ready;
    twd_status_t      stat;

    int               fault_count;
    int               backlog;
    logic [TASKS-1:0] configured_mask;
    logic [TASKS-1:0] active_mask;
    logic [TASKS-1:0] entered_mask;

    int               send_idle_pct = 0;
    int               stall_pct     = 0;
    logic             drain_hold    = 1'b0;

    task_liveness_watchdog uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .evt_valid  (evt_valid),
        .evt_ready  (evt_ready),
        .evt        (evt),
        .stat_valid (stat_valid),
        .stat_ready (stat_ready),
        .stat       (stat)
    );

    twd_status_checker status_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .evt_valid       (evt_valid),
        .evt_ready       (evt_ready),
        .evt             (evt),
        .stat_valid      (stat_valid),
        .stat_ready      (stat_ready),
        .stat            (stat),
        .fault_count     (fault_count),
        .backlog         (backlog),
        .configured_mask (configured_mask),
        .active_mask     (active_mask),
        .entered_mask    (entered_mask)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // offer one event, hold it until the transfer, then maybe idle
    task automatic send_event(input logic [2:0] mode, input logic [7:0] id,
                              input logic [7:0] tmo, input logic act);
        twd_event_t item;
        item.mode    = mode;
        item.task_id = id;
        item.timeout = tmo;
        item.active  = act;
        evt       <= item;
        evt_valid <= 1'b1;
        @(posedge clk);
        while (!evt_ready)
            @(posedge clk);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            evt_valid <= 1'b0;
            @(negedge clk);
        end
    endtask

    // stop offering and wait until every predicted status has come back
    task automatic drain_status();
        evt_valid <= 1'b0;
        while (backlog != 0)
            @(negedge clk);
    endtask

    // random task from a mask, -1 when the mask is empty
    function automatic int pick_task(input logic [TASKS-1:0] mask);
        int base;
        base = $urandom_range(TASKS - 1);
        for (int k = 0; k < TASKS; k++)
            if (mask[(base + k) % TASKS])
                return (base + k) % TASKS;
        return -1;
    endfunction

    // one event that never causes a usage error, so tick walks keep running
    task automatic drive_routine_event();
        int               choice;
        int               slot;
        logic [TASKS-1:0] can_start;
        logic [TASKS-1:0] can_end;
        logic [7:0]       any_id;
        logic [7:0]       any_tmo;
        logic             any_act;
        choice    = $urandom_range(99);
        can_start = configured_mask & active_mask & ~entered_mask;
        can_end   = configured_mask & entered_mask;
        any_id    = 8'($urandom_range(255));
        any_tmo   = 8'($urandom_range(255));
        any_act   = 1'($urandom_range(1));
        slot      = -1;
        if (choice < 12)
        begin
            // short limits mostly, so ticks reach timeouts
            if ($urandom_range(3) == 0)
                send_event(MODE_CONFIG, 8'($urandom_range(TASKS - 1)), any_tmo,
                           1'($urandom_range(4) != 0));
            else
                send_event(MODE_CONFIG, 8'($urandom_range(TASKS - 1)),
                           8'($urandom_range(6)), 1'($urandom_range(4) != 0));
            return;
        end
        else if (choice < 32)
        begin
            slot = pick_task(can_start);
            if (slot >= 0)
            begin
                send_event(MODE_HELLO, 8'(slot), any_tmo, any_act);
                return;
            end
        end
        else if (choice < 44)
        begin
            slot = pick_task(can_start);
            if (slot >= 0)
            begin
                send_event(MODE_START, 8'(slot), any_tmo, any_act);
                return;
            end
        end
        else if (choice < 58)
        begin
            slot = pick_task(can_end);
            if (slot >= 0)
            begin
                send_event(MODE_END, 8'(slot), any_tmo, any_act);
                return;
            end
        end
        else if (choice < 66)
        begin
            if ($urandom_range(1))
                any_id = 8'($urandom_range(TASKS - 1));
            send_event(MODE_SETACT, any_id, any_tmo, any_act);
            return;
        end
        else if (choice < 70)
        begin
            send_event($urandom_range(1) ? MODE_SPARE_HI : MODE_SPARE_LO,
                       any_id, any_tmo, any_act);
            return;
        end
        // tick, also when no task suits the chosen activity
        send_event(MODE_TICK, any_id, any_tmo, any_act);
    endtask

    // status receiver with random stalls and one long hold-off on request
    initial
    begin
        stat_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (drain_hold)
            begin
                stat_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                drain_hold = 1'b0;
            end
            stat_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // end the run when no transfer happens for too long
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((evt_valid && evt_ready) || (stat_valid && stat_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // stimulus and verdict
    initial
    begin
        int slot;
        rst_n     = 1'b0;
        evt_valid = 1'b0;
        evt       = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // idle table, ignored ids and spare modes
        send_event(MODE_TICK, 8'h00, 8'h00, 1'b0);
        send_event(MODE_SETACT, 8'd3, 8'h00, 1'b1);
        send_event(MODE_SETACT, 8'hFF, 8'hFF, 1'b1);
        send_event(MODE_SPARE_HI, 8'hFF, 8'hFF, 1'b1);
        send_event(MODE_SPARE_LO, 8'h00, 8'h00, 1'b0);
        // bracketed activity, counting and a timeout on task 1
        send_event(MODE_CONFIG, 8'd1, 8'd2, 1'b1);
        send_event(MODE_START, 8'd1, 8'h00, 1'b0);
        send_event(MODE_TICK, 8'h00, 8'h00, 1'b0);
        send_event(MODE_TICK, 8'h00, 8'h00, 1'b0);
        send_event(MODE_END, 8'd1, 8'h00, 1'b0);
        send_event(MODE_HELLO, 8'd1, 8'h00, 1'b0);
        repeat (3) send_event(MODE_TICK, 8'h00, 8'h00, 1'b0);
        // largest and zero limits; a zero limit times out on the first tick
        send_event(MODE_CONFIG, 8'd7, 8'hFF, 1'b1);
        send_event(MODE_CONFIG, 8'd0, 8'h00, 1'b1);
        send_event(MODE_TICK, 8'h00, 8'h00, 1'b0);
        // suspended tasks are skipped and lose their entered flag
        send_event(MODE_SETACT, 8'd0, 8'h00, 1'b0);
        send_event(MODE_CONFIG, 8'd1, 8'hFF, 1'b0);
        send_event(MODE_TICK, 8'h00, 8'h00, 1'b0);
        send_event(MODE_START, 8'd7, 8'h00, 1'b0);
        send_event(MODE_SETACT, 8'd7, 8'h00, 1'b0);
        send_event(MODE_TICK, 8'h00, 8'h00, 1'b0);
        send_event(MODE_SETACT, 8'd7, 8'h00, 1'b1);
        // reconfigure keeps the entered flag, so the end still succeeds
        send_event(MODE_START, 8'd7, 8'h00, 1'b0);
        send_event(MODE_CONFIG, 8'd7, 8'd3, 1'b1);
        send_event(MODE_END, 8'd7, 8'h00, 1'b0);
        drain_status();

        // well-formed traffic under each idling pattern
        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 48;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 48;
                end
                default:
                begin
                    send_idle_pct = 17;
                    stall_pct     = 17;
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // long receiver hold-off while events keep coming
                if (p == 0 && n == PHASE_ITEMS / 2)
                    drain_hold = 1'b1;
                drive_routine_event();
            end
            drain_status();
        end

        // usage errors stick until reset, so their checks close the run
        slot = pick_task(configured_mask & active_mask & ~entered_mask);
        if (slot >= 0)
        begin
            send_event(MODE_START, 8'(slot), 8'h00, 1'b0);
            send_event(MODE_START, 8'(slot), 8'h00, 1'b0);
            send_event(MODE_END, 8'(slot), 8'h00, 1'b0);
            send_event(MODE_END, 8'(slot), 8'h00, 1'b0);
        end
        send_event(MODE_START, 8'hFF, 8'h00, 1'b0);
        send_event(MODE_TICK, 8'h00, 8'h00, 1'b0);
        send_event(MODE_END, 8'(TASKS), 8'h00, 1'b0);
        send_event(MODE_HELLO, 8'hFF, 8'h00, 1'b0);
        send_event(MODE_CONFIG, 8'(TASKS), 8'd5, 1'b1);
        send_event(MODE_CONFIG, 8'hFF, 8'hFF, 1'b1);
        repeat (2) send_event(MODE_TICK, 8'h00, 8'h00, 1'b0);

        // unrestricted noise
        for (int n = 0; n < NOISE_ITEMS; n++)
            send_event(3'($urandom_range(7)),
                       $urandom_range(1) ? 8'($urandom_range(TASKS - 1))
                                         : 8'($urandom_range(255)),
                       8'($urandom_range(255)), 1'($urandom_range(1)));

        drain_status();
        repeat (SETTLE) @(negedge clk);
        if (fault_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
src/twd_pkg.sv
src/twd_entry_ram.sv
src/task_liveness_watchdog.sv
test/twd_status_checker.sv
test/task_liveness_watchdog_test.sv
